>>> src/ecstrip_pkg.sv
// shared types, constants and helper functions for the control character stripper
package ecstrip_pkg;

    localparam int SECTION_DEPTH = 32;
    localparam int CNT_W = $clog2(SECTION_DEPTH + 1);
    localparam int IDX_W = (SECTION_DEPTH > 1) ? $clog2(SECTION_DEPTH) : 1;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW = $clog2(FIFO_DEPTH);
    localparam int MASK_W = 33;

    localparam logic [7:0] ESC_BYTE = 8'd92;
    localparam logic [7:0] DEL_BYTE = 8'd127;
    localparam logic [7:0] SPACE_BYTE = 8'd32;
    localparam logic [7:0] DELIM_RESET = 8'd34;

    typedef enum logic [1:0] {
        CFG_DELIM        = 2'd0,
        CFG_ENABLE       = 2'd1,
        CFG_KEEP_OUTER   = 2'd2,
        CFG_KEEP_SECTION = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0]        delim;
        logic              enable;
        logic [MASK_W-1:0] keep_outer;
        logic [MASK_W-1:0] keep_section;
    } cfg_t;

    // one command per accepted item, handed from the front to the back
    typedef struct packed {
        logic [7:0]       data;
        logic             store;
        logic [IDX_W-1:0] store_idx;
        logic             flush;
        logic [CNT_W-1:0] flush_cnt;
        logic             flush_sect;
        logic             flush_ovf;
        logic             emit;
        logic             last;
    } cmd_t;

    typedef enum logic [2:0] {
        B_IDLE = 3'd0,
        B_RD   = 3'd1,
        B_CHK  = 3'd2,
        B_EMIT = 3'd3,
        B_END  = 3'd4
    } back_state_t;

    function automatic logic kept(input logic [7:0] b, input logic [MASK_W-1:0] mask);
        logic [7:0] bm1;
        logic       res;
        bm1 = b - 8'd1;
        if (b == 8'd0)
            res = 1'b0;
        else if (b <= SPACE_BYTE)
            res = mask[bm1[5:0]];
        else if (b == DEL_BYTE)
            res = mask[MASK_W-1];
        else
            res = 1'b1;
        return res;
    endfunction

endpackage

>>> src/escape_aware_control_char_stripper.sv
// top level: configuration registers and the front, queue and back
//
// Strips control bytes (1..32) and 127 from a text stream, with keep masks
// for bytes outside and inside delimited sections.
// Input channel in_valid/in_ready carries in_byte and in_last; in_last marks
// the final byte of a text. Output channel out_valid/out_ready carries
// out_byte, out_empty, out_last and out_overflow; out_empty marks an end-only
// item when the last byte of a text produced nothing.
// Configuration channel cfg_valid/cfg_ready takes cfg_index and cfg_data; it
// is always ready and must only be used while the block is idle.
// The back sequencer handles a buffered section byte or deleted outer byte in
// its idle state alone, adds the emit and end states for a kept outer byte,
// delimiter or end-only item, and a read and a check state per byte of a
// section flush, since each buffer read is registered; a 4-entry command
// queue lets the front keep accepting while the back works.
// Reset clears all escape and section state and loads register defaults;
// the section buffer is not cleared. If the receiver stalls, the output
// register and one staging register fill, then the queue, then in_ready drops.
module escape_aware_control_char_stripper (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      in_byte,
    input  logic                            in_last,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [7:0]                      out_byte,
    output logic                            out_empty,
    output logic                            out_last,
    output logic                            out_overflow,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [1:0]                      cfg_index,
    input  logic [ecstrip_pkg::MASK_W-1:0]  cfg_data
);

    ecstrip_pkg::cfg_t cfg_reg;
    ecstrip_pkg::cmd_t push_cmd;
    ecstrip_pkg::cmd_t head_cmd;
    logic              fifo_full;
    logic              fifo_empty;
    logic              fifo_push;
    logic              fifo_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.delim        <= ecstrip_pkg::DELIM_RESET;
            cfg_reg.enable       <= 1'b0;
            cfg_reg.keep_outer   <= '0;
            cfg_reg.keep_section <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (ecstrip_pkg::cfg_reg_t'(cfg_index))
                ecstrip_pkg::CFG_DELIM:        cfg_reg.delim        <= cfg_data[7:0];
                ecstrip_pkg::CFG_ENABLE:       cfg_reg.enable       <= cfg_data[0];
                ecstrip_pkg::CFG_KEEP_OUTER:   cfg_reg.keep_outer   <= cfg_data;
                ecstrip_pkg::CFG_KEEP_SECTION: cfg_reg.keep_section <= cfg_data;
                default:                       cfg_reg.enable       <= cfg_reg.enable;
            endcase
        end
    end

    ecstrip_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .fifo_full (fifo_full),
        .fifo_push (fifo_push),
        .fifo_cmd  (push_cmd)
    );

    ecstrip_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fifo_push),
        .push_data (push_cmd),
        .full      (fifo_full),
        .pop       (fifo_pop),
        .head      (head_cmd),
        .empty     (fifo_empty)
    );

    ecstrip_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .fifo_empty   (fifo_empty),
        .fifo_head    (head_cmd),
        .fifo_pop     (fifo_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .out_empty    (out_empty),
        .out_last     (out_last),
        .out_overflow (out_overflow)
    );

endmodule

>>> src/ecstrip_front.sv
// front end: accepts items, tracks escape and section state, issues commands
module ecstrip_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ecstrip_pkg::cfg_t    cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           in_byte,
    input  logic                 in_last,
    input  logic                 fifo_full,
    output logic                 fifo_push,
    output ecstrip_pkg::cmd_t    fifo_cmd
);

    logic                          outer_esc_reg, outer_esc_next;
    logic                          in_sect_reg, in_sect_next;
    logic                          sect_esc_reg, sect_esc_next;
    logic [ecstrip_pkg::CNT_W-1:0] count_reg, count_next;
    logic                          accept;
    logic                          sect_on;
    logic                          sect_full;
    logic                          esc_use;
    logic                          run_outer;

    assign in_ready  = !fifo_full;
    assign accept    = in_valid && in_ready;
    assign fifo_push = accept;

    assign sect_on = cfg.enable && (cfg.delim != ecstrip_pkg::ESC_BYTE) && (cfg.delim != 8'd0);
    assign sect_full = (count_reg >= ecstrip_pkg::CNT_W'(ecstrip_pkg::SECTION_DEPTH));

    always_comb
    begin
        fifo_cmd       = '0;
        fifo_cmd.data  = in_byte;
        fifo_cmd.last  = in_last;
        outer_esc_next = outer_esc_reg;
        in_sect_next   = in_sect_reg;
        sect_esc_next  = sect_esc_reg;
        count_next     = count_reg;
        esc_use        = outer_esc_reg;
        run_outer      = 1'b0;

        if (in_sect_reg)
        begin
            if (in_byte != 8'd0 && in_byte == cfg.delim && !sect_esc_reg)
            begin
                // closing delimiter: section rules, then the delimiter itself
                fifo_cmd.flush      = 1'b1;
                fifo_cmd.flush_cnt  = count_reg;
                fifo_cmd.flush_sect = 1'b1;
                fifo_cmd.emit       = 1'b1;
                in_sect_next        = 1'b0;
                sect_esc_next       = 1'b0;
                outer_esc_next      = 1'b0;
                count_next          = '0;
            end
            else if (in_last || sect_full)
            begin
                // unclosed at end or buffer overflow: outer rules, byte goes outside
                fifo_cmd.flush     = 1'b1;
                fifo_cmd.flush_cnt = count_reg;
                fifo_cmd.flush_ovf = sect_full;
                in_sect_next       = 1'b0;
                esc_use            = sect_esc_reg;
                sect_esc_next      = 1'b0;
                count_next         = '0;
                run_outer          = 1'b1;
            end
            else
            begin
                fifo_cmd.store     = 1'b1;
                fifo_cmd.store_idx = count_reg[ecstrip_pkg::IDX_W-1:0];
                count_next         = count_reg + ecstrip_pkg::CNT_W'(1);
                sect_esc_next      = (in_byte == ecstrip_pkg::ESC_BYTE) ? !sect_esc_reg : 1'b0;
            end
        end
        else
        begin
            run_outer = 1'b1;
        end

        if (run_outer)
        begin
            if (sect_on && in_byte == cfg.delim && !esc_use)
            begin
                fifo_cmd.emit  = 1'b1;
                in_sect_next   = 1'b1;
                sect_esc_next  = 1'b0;
                count_next     = '0;
                outer_esc_next = 1'b0;
            end
            else
            begin
                fifo_cmd.emit  = ecstrip_pkg::kept(in_byte, cfg.keep_outer);
                outer_esc_next = (in_byte == ecstrip_pkg::ESC_BYTE) ? !esc_use : 1'b0;
            end
        end

        if (in_last)
        begin
            outer_esc_next = 1'b0;
            in_sect_next   = 1'b0;
            sect_esc_next  = 1'b0;
            count_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outer_esc_reg <= 1'b0;
            in_sect_reg   <= 1'b0;
            sect_esc_reg  <= 1'b0;
            count_reg     <= '0;
        end
        else if (accept)
        begin
            outer_esc_reg <= outer_esc_next;
            in_sect_reg   <= in_sect_next;
            sect_esc_reg  <= sect_esc_next;
            count_reg     <= count_next;
        end
    end

endmodule

>>> src/ecstrip_fifo.sv
// short command queue between the front and the back
module ecstrip_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  ecstrip_pkg::cmd_t    push_data,
    output logic                 full,
    input  logic                 pop,
    output ecstrip_pkg::cmd_t    head,
    output logic                 empty
);

    ecstrip_pkg::cmd_t             entry_reg [ecstrip_pkg::FIFO_DEPTH];
    logic [ecstrip_pkg::FIFO_AW:0] wr_ptr_reg;
    logic [ecstrip_pkg::FIFO_AW:0] rd_ptr_reg;

    assign empty = (wr_ptr_reg == rd_ptr_reg);
    assign full  = (wr_ptr_reg[ecstrip_pkg::FIFO_AW] != rd_ptr_reg[ecstrip_pkg::FIFO_AW]) &&
                   (wr_ptr_reg[ecstrip_pkg::FIFO_AW-1:0] == rd_ptr_reg[ecstrip_pkg::FIFO_AW-1:0]);
    assign head  = entry_reg[rd_ptr_reg[ecstrip_pkg::FIFO_AW-1:0]];

    always_ff @(posedge clk)
    begin
        if (push && !full)
            entry_reg[wr_ptr_reg[ecstrip_pkg::FIFO_AW-1:0]] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (push && !full)
                wr_ptr_reg <= wr_ptr_reg + (ecstrip_pkg::FIFO_AW + 1)'(1);
            if (pop && !empty)
                rd_ptr_reg <= rd_ptr_reg + (ecstrip_pkg::FIFO_AW + 1)'(1);
        end
    end

endmodule

>>> src/ecstrip_back.sv
// back end: section buffer, flush sequencer and output staging
module ecstrip_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ecstrip_pkg::cfg_t    cfg,
    input  logic                 fifo_empty,
    input  ecstrip_pkg::cmd_t    fifo_head,
    output logic                 fifo_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_byte,
    output logic                 out_empty,
    output logic                 out_last,
    output logic                 out_overflow
);

    logic [7:0]                    buf_mem [ecstrip_pkg::SECTION_DEPTH];
    logic [7:0]                    rd_reg;
    logic                          mem_we;

    ecstrip_pkg::back_state_t      state_reg, state_next;
    ecstrip_pkg::cmd_t             cmd_reg, cmd_next;
    logic [ecstrip_pkg::CNT_W-1:0] idx_reg, idx_next;
    logic [ecstrip_pkg::CNT_W-1:0] idx_inc;

    logic                          pend_valid_reg, pend_valid_next;
    logic [7:0]                    pend_data_reg, pend_data_next;
    logic                          pend_ovf_reg, pend_ovf_next;

    logic                          out_valid_reg, out_valid_next;
    logic [7:0]                    out_data_reg, out_data_next;
    logic                          out_empty_reg, out_empty_next;
    logic                          out_last_reg, out_last_next;
    logic                          out_ovf_reg, out_ovf_next;

    logic                          move_ok;
    logic                          push_ok;
    logic                          push_req;
    logic [7:0]                    push_data;
    logic                          push_ovf;
    logic [ecstrip_pkg::MASK_W-1:0] mask_sel;

    assign move_ok  = !out_valid_reg || out_ready;
    assign push_ok  = !pend_valid_reg || move_ok;
    assign idx_inc  = idx_reg + ecstrip_pkg::CNT_W'(1);
    assign mask_sel = cmd_reg.flush_sect ? cfg.keep_section : cfg.keep_outer;

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_data_reg;
    assign out_empty    = out_empty_reg;
    assign out_last     = out_last_reg;
    assign out_overflow = out_ovf_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            buf_mem[fifo_head.store_idx] <= fifo_head.data;
        if (state_reg == ecstrip_pkg::B_RD)
            rd_reg <= buf_mem[idx_reg[ecstrip_pkg::IDX_W-1:0]];
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_data_next  = pend_data_reg;
        pend_ovf_next   = pend_ovf_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_empty_next  = out_empty_reg;
        out_last_next   = out_last_reg;
        out_ovf_next    = out_ovf_reg;
        fifo_pop        = 1'b0;
        mem_we          = 1'b0;
        push_req        = 1'b0;
        push_data       = cmd_reg.data;
        push_ovf        = 1'b0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ecstrip_pkg::B_IDLE:
            begin
                if (!fifo_empty)
                begin
                    fifo_pop = 1'b1;
                    cmd_next = fifo_head;
                    mem_we   = fifo_head.store;
                    if (fifo_head.flush && fifo_head.flush_cnt != '0)
                    begin
                        idx_next   = '0;
                        state_next = ecstrip_pkg::B_RD;
                    end
                    else if (fifo_head.emit || fifo_head.last)
                    begin
                        state_next = ecstrip_pkg::B_EMIT;
                    end
                end
            end
            ecstrip_pkg::B_RD:
            begin
                state_next = ecstrip_pkg::B_CHK;
            end
            ecstrip_pkg::B_CHK:
            begin
                push_req  = ecstrip_pkg::kept(rd_reg, mask_sel);
                push_data = rd_reg;
                push_ovf  = cmd_reg.flush_ovf;
                if (!push_req || push_ok)
                begin
                    idx_next   = idx_inc;
                    state_next = (idx_inc == cmd_reg.flush_cnt) ? ecstrip_pkg::B_EMIT
                                                                : ecstrip_pkg::B_RD;
                end
            end
            ecstrip_pkg::B_EMIT:
            begin
                push_req = cmd_reg.emit;
                if (!push_req || push_ok)
                    state_next = ecstrip_pkg::B_END;
            end
            ecstrip_pkg::B_END:
            begin
                // staged item goes out, carrying the end mark if this was the last item
                if (pend_valid_reg)
                begin
                    if (move_ok)
                    begin
                        out_valid_next  = 1'b1;
                        out_data_next   = pend_data_reg;
                        out_empty_next  = 1'b0;
                        out_last_next   = cmd_reg.last;
                        out_ovf_next    = pend_ovf_reg;
                        pend_valid_next = 1'b0;
                        state_next      = ecstrip_pkg::B_IDLE;
                    end
                end
                else if (cmd_reg.last)
                begin
                    if (move_ok)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = 8'd0;
                        out_empty_next = 1'b1;
                        out_last_next  = 1'b1;
                        out_ovf_next   = 1'b0;
                        state_next     = ecstrip_pkg::B_IDLE;
                    end
                end
                else
                begin
                    state_next = ecstrip_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = ecstrip_pkg::B_IDLE;
            end
        endcase

        // one item of lookahead so the end mark lands on the final result
        if (push_req && push_ok)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_data_next  = pend_data_reg;
                out_empty_next = 1'b0;
                out_last_next  = 1'b0;
                out_ovf_next   = pend_ovf_reg;
            end
            pend_valid_next = 1'b1;
            pend_data_next  = push_data;
            pend_ovf_next   = push_ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ecstrip_pkg::B_IDLE;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        pend_data_reg <= pend_data_next;
        pend_ovf_reg  <= pend_ovf_next;
        out_data_reg  <= out_data_next;
        out_empty_reg <= out_empty_next;
        out_last_reg  <= out_last_next;
        out_ovf_reg   <= out_ovf_next;
    end

    // staging register is always drained before the next command is taken
    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ecstrip_pkg::B_IDLE |-> !pend_valid_reg)
        else $error("staged item left behind at idle");

    a_empty_marker: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_empty_reg |-> out_last_reg && out_data_reg == 8'd0 && !out_ovf_reg)
        else $error("malformed end-only item");

    a_flush_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ecstrip_pkg::B_RD || state_reg == ecstrip_pkg::B_CHK)
        |-> idx_reg < cmd_reg.flush_cnt)
        else $error("flush index past buffered count");

endmodule

>>> test/escape_aware_control_char_stripper_tb.sv
// testbench for the control character stripper: table-driven and random streams
module escape_aware_control_char_stripper_tb;

    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES = 200;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 400;

    typedef struct packed {
        logic [7:0] data;
        logic       empty;
        logic       last;
        logic       ovf;
    } res_t;

    typedef enum logic [1:0] {ROW_ITEM, ROW_CFG} row_kind_t;
    typedef enum logic [1:0] {CHK_PRED, CHK_ONE, CHK_NONE} chk_t;

    typedef struct packed {
        row_kind_t                      kind;
        ecstrip_pkg::cfg_reg_t          idx;
        logic [ecstrip_pkg::MASK_W-1:0] val;
        logic [7:0]                     b;
        logic                           l;
        int                             rep;
        chk_t                           chk;
        res_t                           want;
    } row_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic [7:0]                     in_byte = 8'd0;
    logic                           in_last = 1'b0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [7:0]                     out_byte;
    logic                           out_empty;
    logic                           out_last;
    logic                           out_overflow;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    ecstrip_pkg::cfg_reg_t          cfg_index = ecstrip_pkg::CFG_DELIM;
    logic [ecstrip_pkg::MASK_W-1:0] cfg_data = '0;

    // predictor copy of the registers and of the filter state
    logic [7:0]                     pc_delim;
    logic                           pc_enable;
    logic [ecstrip_pkg::MASK_W-1:0] pc_keep_outer;
    logic [ecstrip_pkg::MASK_W-1:0] pc_keep_section;
    logic                           st_out_esc;
    logic                           st_in_sect;
    logic                           st_sect_esc;
    logic [7:0]                     sect_buf [ecstrip_pkg::SECTION_DEPTH];
    int                             sect_cnt;
    res_t                           pend [ecstrip_pkg::SECTION_DEPTH+2];
    int                             pend_n;

    res_t exp_chars[$];
    row_t dir_rows[$];
    int   mismatches = 0;
    int   items_sent = 0;
    int   cycle_cnt = 0;
    bit   burst = 1'b0;
    bit   hold_req = 1'b0;

    escape_aware_control_char_stripper dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .in_last      (in_last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .out_empty    (out_empty),
        .out_last     (out_last),
        .out_overflow (out_overflow),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic ctrl_kept(input logic [7:0] b,
                                       input logic [ecstrip_pkg::MASK_W-1:0] mask);
        logic [7:0] bm1;
        logic       k;
        bm1 = b - 8'd1;
        if (b == 8'd0)
            k = 1'b0;
        else if (b <= ecstrip_pkg::SPACE_BYTE)
            k = mask[bm1[5:0]];
        else if (b == ecstrip_pkg::DEL_BYTE)
            k = mask[ecstrip_pkg::MASK_W-1];
        else
            k = 1'b1;
        return k;
    endfunction

    function automatic void emit_exp(input logic [7:0] b, input logic ovf);
        pend[pend_n] = {b, 1'b0, 1'b0, ovf};
        pend_n++;
    endfunction

    function automatic void drain_section(input logic [ecstrip_pkg::MASK_W-1:0] mask,
                                          input logic ovf);
        for (int i = 0; i < sect_cnt; i++)
        begin
            if (ctrl_kept(sect_buf[i], mask))
                emit_exp(sect_buf[i], ovf);
        end
        sect_cnt = 0;
    endfunction

    function automatic void outer_step(input logic [7:0] b);
        logic on;
        on = pc_enable && pc_delim != ecstrip_pkg::ESC_BYTE && pc_delim != 8'd0;
        if (on && b == pc_delim && !st_out_esc)
        begin
            emit_exp(b, 1'b0);
            st_in_sect = 1'b1;
            st_sect_esc = 1'b0;
            sect_cnt = 0;
            st_out_esc = 1'b0;
        end
        else
        begin
            if (ctrl_kept(b, pc_keep_outer))
                emit_exp(b, 1'b0);
            st_out_esc = (b == ecstrip_pkg::ESC_BYTE) ? !st_out_esc : 1'b0;
        end
    endfunction

    // works out the results of one accepted item into pend
    function automatic void filter_step(input logic [7:0] b, input logic l);
        logic ovf;
        pend_n = 0;
        if (st_in_sect)
        begin
            if (b != 8'd0 && b == pc_delim && !st_sect_esc)
            begin
                drain_section(pc_keep_section, 1'b0);
                emit_exp(b, 1'b0);
                st_in_sect = 1'b0;
                st_sect_esc = 1'b0;
                st_out_esc = 1'b0;
            end
            else if (l || sect_cnt >= ecstrip_pkg::SECTION_DEPTH)
            begin
                ovf = (sect_cnt >= ecstrip_pkg::SECTION_DEPTH);
                drain_section(pc_keep_outer, ovf);
                st_in_sect = 1'b0;
                st_out_esc = st_sect_esc;
                st_sect_esc = 1'b0;
                outer_step(b);
            end
            else
            begin
                sect_buf[sect_cnt] = b;
                sect_cnt++;
                st_sect_esc = (b == ecstrip_pkg::ESC_BYTE) ? !st_sect_esc : 1'b0;
            end
        end
        else
            outer_step(b);
        if (l)
        begin
            // end-only result when the last byte left nothing
            if (pend_n == 0)
            begin
                pend[0] = {8'd0, 1'b1, 1'b0, 1'b0};
                pend_n = 1;
            end
            pend[pend_n-1].last = 1'b1;
            st_out_esc = 1'b0;
            st_in_sect = 1'b0;
            st_sect_esc = 1'b0;
            sect_cnt = 0;
        end
    endfunction

    function automatic void tab_item(input logic [7:0] b, input logic l, input int rep);
        row_t r;
        r = '0;
        r.kind = ROW_ITEM;
        r.b = b;
        r.l = l;
        r.rep = rep;
        r.chk = CHK_PRED;
        dir_rows.push_back(r);
    endfunction

    function automatic void tab_check(input logic [7:0] b, input logic l, input chk_t chk,
                                      input res_t want);
        row_t r;
        r = '0;
        r.kind = ROW_ITEM;
        r.b = b;
        r.l = l;
        r.rep = 1;
        r.chk = chk;
        r.want = want;
        dir_rows.push_back(r);
    endfunction

    function automatic void tab_cfg(input ecstrip_pkg::cfg_reg_t idx,
                                    input logic [ecstrip_pkg::MASK_W-1:0] val);
        row_t r;
        r = '0;
        r.kind = ROW_CFG;
        r.idx = idx;
        r.val = val;
        dir_rows.push_back(r);
    endfunction

    function automatic logic [7:0] rand_text_byte(input logic [7:0] avoid);
        logic [7:0] v;
        int         r;
        do
        begin
            r = $urandom_range(0, 19);
            if (r < 6)
                v = 8'($urandom_range(1, 32));
            else if (r < 7)
                v = ecstrip_pkg::DEL_BYTE;
            else if (r < 9)
                v = ecstrip_pkg::ESC_BYTE;
            else if (r < 12)
                v = 8'($urandom_range(128, 255));
            else
                v = 8'($urandom_range(33, 126));
        end
        while (v == avoid);
        return v;
    endfunction

    function automatic logic [ecstrip_pkg::MASK_W-1:0] rand_mask();
        logic [ecstrip_pkg::MASK_W-1:0] m;
        case ($urandom_range(0, 3))
            0: m = '0;
            1: m = '1;
            default: m = {1'($urandom_range(0, 1)), 32'($urandom())};
        endcase
        return m;
    endfunction

    task automatic offer(input logic [7:0] b, input logic l, input chk_t chk, input res_t want);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 3);
        repeat (gap)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        in_last <= l;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        filter_step(b, l);
        if (chk == CHK_PRED)
        begin
            for (int i = 0; i < pend_n; i++)
                exp_chars.push_back(pend[i]);
        end
        else if (chk == CHK_ONE)
            exp_chars.push_back(want);
        items_sent++;
    endtask

    // registers change only once the block has drained
    task automatic write_reg(input ecstrip_pkg::cfg_reg_t idx,
                             input logic [ecstrip_pkg::MASK_W-1:0] val);
        in_valid <= 1'b0;
        while (exp_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        case (idx)
            ecstrip_pkg::CFG_DELIM:      pc_delim = val[7:0];
            ecstrip_pkg::CFG_ENABLE:     pc_enable = val[0];
            ecstrip_pkg::CFG_KEEP_OUTER: pc_keep_outer = val;
            default:                     pc_keep_section = val;
        endcase
    endtask

    task automatic new_settings();
        logic [7:0] d;
        case ($urandom_range(0, 5))
            0: d = 8'd1;
            1: d = 8'd255;
            2: d = ecstrip_pkg::DELIM_RESET;
            3: d = ecstrip_pkg::ESC_BYTE;
            default: d = 8'($urandom_range(1, 255));
        endcase
        write_reg(ecstrip_pkg::CFG_DELIM, ecstrip_pkg::MASK_W'(d));
        write_reg(ecstrip_pkg::CFG_ENABLE, ecstrip_pkg::MASK_W'($urandom_range(0, 4) != 0));
        write_reg(ecstrip_pkg::CFG_KEEP_OUTER, rand_mask());
        write_reg(ecstrip_pkg::CFG_KEEP_SECTION, rand_mask());
    endtask

    // one text: mostly outer runs with delimited sections, sometimes plain noise
    task automatic send_text();
        logic [7:0] txt[$];
        int         segs;
        int         len;
        int         r;
        burst = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 9) == 0)
        begin
            len = $urandom_range(1, 12);
            repeat (len) txt.push_back(8'($urandom_range(1, 255)));
        end
        else
        begin
            segs = $urandom_range(1, 3);
            repeat (segs)
            begin
                repeat ($urandom_range(0, 4)) txt.push_back(rand_text_byte(pc_delim));
                if ($urandom_range(0, 7) == 0)
                    txt.push_back(ecstrip_pkg::ESC_BYTE);
                txt.push_back(pc_delim);
                r = $urandom_range(0, 9);
                if (r < 7)
                    len = $urandom_range(0, 8);
                else if (r < 9)
                    len = $urandom_range(ecstrip_pkg::SECTION_DEPTH - 2,
                                         ecstrip_pkg::SECTION_DEPTH);
                else
                    len = $urandom_range(ecstrip_pkg::SECTION_DEPTH + 1,
                                         ecstrip_pkg::SECTION_DEPTH + 8);
                while (len > 0)
                begin
                    // escaped delimiter inside the section body
                    if ($urandom_range(0, 6) == 0)
                    begin
                        txt.push_back(ecstrip_pkg::ESC_BYTE);
                        txt.push_back(pc_delim);
                        len -= 2;
                    end
                    else
                    begin
                        txt.push_back(rand_text_byte(pc_delim));
                        len--;
                    end
                end
                if ($urandom_range(0, 6) != 0)
                    txt.push_back(pc_delim);
            end
            repeat ($urandom_range(0, 3)) txt.push_back(rand_text_byte(pc_delim));
        end
        foreach (txt[i])
            offer(txt[i], i == txt.size() - 1, CHK_PRED, '0);
    endtask

    task automatic check_field(input string what, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    // receiver side
    initial
    begin
        int   gap;
        res_t e;
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            gap = burst ? 0 : $urandom_range(0, 3);
            repeat (gap)
            begin
                out_ready <= 1'b0;
                @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
            if (exp_chars.size() == 0)
            begin
                $display("%0t: item with nothing expected: byte %0d empty %0b last %0b ovf %0b",
                         $time, out_byte, out_empty, out_last, out_overflow);
                mismatches++;
            end
            else
            begin
                e = exp_chars.pop_front();
                check_field("out_byte", e.data, out_byte);
                check_field("out_empty", 8'(e.empty), 8'(out_empty));
                check_field("out_last", 8'(e.last), 8'(out_last));
                check_field("out_overflow", 8'(e.ovf), 8'(out_overflow));
            end
        end
    end

    // sender side and run control
    initial
    begin
        int rand_start;
        pc_delim = ecstrip_pkg::DELIM_RESET;
        pc_enable = 1'b0;
        pc_keep_outer = '0;
        pc_keep_section = '0;
        st_out_esc = 1'b0;
        st_in_sect = 1'b0;
        st_sect_esc = 1'b0;
        sect_cnt = 0;

        // register defaults, extremes of the byte range, end-only result
        tab_check(8'd65, 1'b0, CHK_ONE, {8'd65, 3'b000});
        tab_check(8'd1, 1'b0, CHK_NONE, '0);
        tab_check(ecstrip_pkg::SPACE_BYTE, 1'b0, CHK_NONE, '0);
        tab_check(ecstrip_pkg::DEL_BYTE, 1'b0, CHK_NONE, '0);
        tab_check(ecstrip_pkg::DELIM_RESET, 1'b0, CHK_ONE, {ecstrip_pkg::DELIM_RESET, 3'b000});
        tab_check(8'd255, 1'b1, CHK_ONE, {8'd255, 3'b010});
        tab_check(8'd9, 1'b1, CHK_ONE, {8'd0, 3'b110});
        tab_cfg(ecstrip_pkg::CFG_KEEP_OUTER, '1);
        tab_check(8'd1, 1'b0, CHK_ONE, {8'd1, 3'b000});
        tab_check(ecstrip_pkg::DEL_BYTE, 1'b1, CHK_ONE, {ecstrip_pkg::DEL_BYTE, 3'b010});
        // sections on: outer keeps 127 only, sections keep space only
        tab_cfg(ecstrip_pkg::CFG_KEEP_OUTER, 33'h1_0000_0000);
        tab_cfg(ecstrip_pkg::CFG_KEEP_SECTION, 33'h0_8000_0000);
        tab_cfg(ecstrip_pkg::CFG_ENABLE, 33'd1);
        tab_item(8'd97, 1'b0, 1);
        tab_item(ecstrip_pkg::DELIM_RESET, 1'b0, 1);
        tab_item(ecstrip_pkg::SPACE_BYTE, 1'b0, 1);
        tab_item(8'd9, 1'b0, 1);
        tab_item(ecstrip_pkg::ESC_BYTE, 1'b0, 1);
        tab_item(ecstrip_pkg::DELIM_RESET, 1'b0, 1);
        tab_item(ecstrip_pkg::DELIM_RESET, 1'b0, 1);
        // escaped opener stays an outer byte
        tab_item(ecstrip_pkg::ESC_BYTE, 1'b0, 1);
        tab_item(ecstrip_pkg::DELIM_RESET, 1'b0, 1);
        // section still open at the end
        tab_item(ecstrip_pkg::DELIM_RESET, 1'b0, 1);
        tab_item(ecstrip_pkg::SPACE_BYTE, 1'b0, 1);
        tab_item(ecstrip_pkg::DEL_BYTE, 1'b1, 1);
        // buffer overflow, then a full buffer at the end
        tab_item(ecstrip_pkg::DELIM_RESET, 1'b0, 1);
        tab_item(8'd65, 1'b0, ecstrip_pkg::SECTION_DEPTH);
        tab_item(8'd66, 1'b0, 1);
        tab_item(ecstrip_pkg::DELIM_RESET, 1'b0, 1);
        tab_item(8'd67, 1'b0, ecstrip_pkg::SECTION_DEPTH);
        tab_item(8'd68, 1'b1, 1);
        tab_cfg(ecstrip_pkg::CFG_DELIM, 33'd255);
        tab_item(8'd255, 1'b0, 1);
        tab_item(8'd1, 1'b0, 1);
        tab_item(8'd255, 1'b1, 1);
        // backslash as delimiter turns sections off
        tab_cfg(ecstrip_pkg::CFG_DELIM, ecstrip_pkg::MASK_W'(ecstrip_pkg::ESC_BYTE));
        tab_item(ecstrip_pkg::ESC_BYTE, 1'b0, 1);
        tab_item(ecstrip_pkg::DELIM_RESET, 1'b1, 1);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
                write_reg(dir_rows[i].idx, dir_rows[i].val);
            else
                repeat (dir_rows[i].rep)
                    offer(dir_rows[i].b, dir_rows[i].l, dir_rows[i].chk, dir_rows[i].want);
        end

        rand_start = items_sent;
        new_settings();
        // receiver holds off while the sender keeps pushing bytes from 128 to 255
        hold_req = 1'b1;
        burst = 1'b1;
        for (int i = 0; i < 48; i++)
            offer(8'($urandom_range(128, 255)), i == 47, CHK_PRED, '0);
        while (items_sent - rand_start < RANDOM_ITEMS)
        begin
            repeat ($urandom_range(2, 5)) send_text();
            burst = 1'b0;
            new_settings();
        end

        burst = 1'b0;
        in_valid <= 1'b0;
        while (exp_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> escape_aware_control_char_stripper.f
src/ecstrip_pkg.sv
src/ecstrip_front.sv
src/ecstrip_fifo.sv
src/ecstrip_back.sv
src/escape_aware_control_char_stripper.sv
test/escape_aware_control_char_stripper_tb.sv
